// ===== hw/rtl/cc20_pkg.sv =====
// Shared definitions for the ChaCha20 byte-stream cipher.
// Holds constants, register indexes, command and status structs and helpers.
// No dependencies.
package cc20_pkg;

  // Default number of rounds (odd counts round up to the next double round)
  localparam int ROUND_COUNT_DEF = 20;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PART0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PART1   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PART2   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PART3   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_LOW   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_HIGH  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_COUNT = 3'd6;

  // Block constant "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // Quarter-round sub-steps, one add and one xor-rotate each
  localparam logic [1:0] QR_STEP_AD0 = 2'd0;
  localparam logic [1:0] QR_STEP_CB0 = 2'd1;
  localparam logic [1:0] QR_STEP_AD1 = 2'd2;
  localparam logic [1:0] QR_STEP_CB1 = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       accept;    // input word taken this cycle
    logic       round_en;  // apply one quarter-round sub-step on all lanes
    logic [1:0] qr_step;   // which sub-step
    logic       diag;      // diagonal half-round when set, column otherwise
    logic       feed;      // add the initial block into the round state
    logic       emit;      // write the deferred result into the output register
  } cc20_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pos_zero;  // next word starts a new keystream block
    logic out_free;  // output register can take a word this cycle
  } cc20_status_t;

  // Rotate left by a fixed amount
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

endpackage

// ===== hw/rtl/cc20_datapath.sv =====
// Datapath of the ChaCha20 unit: configuration, round state, positions, output.
// Depends on cc20_pkg; driven by cc20_controller commands.
module cc20_datapath import cc20_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cc20_cmd_t              cmd,
  output cc20_status_t           status,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  logic [63:0] key_part0;
  logic [63:0] key_part1;
  logic [63:0] key_part2;
  logic [63:0] key_part3;
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;
  logic [31:0] start_counter;

  logic [5:0]  byte_position;
  logic [31:0] block_index;
  logic [31:0] ctr_word;
  logic [7:0]  hold_byte;
  logic        hold_last;

  logic [31:0] round_state      [16];
  logic [31:0] round_state_next [16];
  logic [31:0] init_word        [16];
  logic [31:0] ctr_sel;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;
  logic        out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_part0     <= '0;
      key_part1     <= '0;
      key_part2     <= '0;
      key_part3     <= '0;
      nonce_low     <= '0;
      nonce_high    <= '0;
      start_counter <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KEY_PART0:   key_part0     <= cfg_data;
        CFG_KEY_PART1:   key_part1     <= cfg_data;
        CFG_KEY_PART2:   key_part2     <= cfg_data;
        CFG_KEY_PART3:   key_part3     <= cfg_data;
        CFG_NONCE_LOW:   nonce_low     <= cfg_data;
        CFG_NONCE_HIGH:  nonce_high    <= cfg_data[31:0];
        CFG_START_COUNT: start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Initial block; the counter word is latched for the feed-forward add
  assign ctr_sel = cmd.feed ? ctr_word : start_counter + block_index;

  always_comb begin
    init_word[0]  = SIGMA0;
    init_word[1]  = SIGMA1;
    init_word[2]  = SIGMA2;
    init_word[3]  = SIGMA3;
    init_word[4]  = key_part0[31:0];
    init_word[5]  = key_part0[63:32];
    init_word[6]  = key_part1[31:0];
    init_word[7]  = key_part1[63:32];
    init_word[8]  = key_part2[31:0];
    init_word[9]  = key_part2[63:32];
    init_word[10] = key_part3[31:0];
    init_word[11] = key_part3[63:32];
    init_word[12] = ctr_sel;
    init_word[13] = nonce_low[31:0];
    init_word[14] = nonce_low[63:32];
    init_word[15] = nonce_high;
  end

  // One quarter-round sub-step on four independent lanes
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] va, vb, vc, vd;
    logic [1:0]  sh;
    round_state_next = round_state;
    for (int l = 0; l < 4; l++) begin
      sh = cmd.diag ? 2'd1 : 2'd0;
      ia = 4'(l);
      ib = {2'b01, 2'(l) + sh};
      ic = {2'b10, 2'(l) + 2'(sh << 1)};
      id = {2'b11, 2'(l) + 2'(sh * 2'd3)};
      va = round_state[ia];
      vb = round_state[ib];
      vc = round_state[ic];
      vd = round_state[id];
      unique case (cmd.qr_step)
        QR_STEP_AD0: begin
          va = va + vb;
          vd = rotl32(vd ^ va, 16);
        end
        QR_STEP_CB0: begin
          vc = vc + vd;
          vb = rotl32(vb ^ vc, 12);
        end
        QR_STEP_AD1: begin
          va = va + vb;
          vd = rotl32(vd ^ va, 8);
        end
        QR_STEP_CB1: begin
          vc = vc + vd;
          vb = rotl32(vb ^ vc, 7);
        end
        default: ;
      endcase
      round_state_next[ia] = va;
      round_state_next[ib] = vb;
      round_state_next[ic] = vc;
      round_state_next[id] = vd;
    end
  end

  // Round state: load, step, feed forward
  always_ff @(posedge clk) begin
    if (cmd.accept && status.pos_zero) begin
      round_state <= init_word;
      ctr_word    <= ctr_sel;
    end else if (cmd.round_en) begin
      round_state <= round_state_next;
    end else if (cmd.feed) begin
      for (int i = 0; i < 16; i++) begin
        round_state[i] <= round_state[i] + init_word[i];
      end
    end
  end

  // Byte position and block index advance per accepted word; a last byte clears both
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      block_index   <= '0;
    end else if (cmd.accept) begin
      if (last_byte) begin
        byte_position <= '0;
        block_index   <= '0;
      end else begin
        byte_position <= byte_position + 6'd1;
        if (byte_position == 6'd63) begin
          block_index <= block_index + 32'd1;
        end
      end
    end
  end

  // Hold the input word while a new block is generated
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_byte <= data_byte;
      hold_last <= last_byte;
    end
  end

  // Keystream byte, little endian from word 0 upward
  assign ks_word = round_state[byte_position[5:2]];
  assign ks_byte = ks_word[{byte_position[1:0], 3'b000} +: 8];

  // Output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && !status.pos_zero) || cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !status.pos_zero) begin
      out_byte <= data_byte ^ ks_byte;
      out_last <= last_byte;
    end else if (cmd.emit) begin
      out_byte <= hold_byte ^ round_state[0][7:0];
      out_last <= hold_last;
    end
  end

  assign status.pos_zero = (byte_position == 6'd0);
  assign status.out_free = out_free;

endmodule

// ===== hw/rtl/cc20_controller.sv =====
// Sequencer of the ChaCha20 unit: accepts words, runs rounds, releases results.
// Depends on cc20_pkg; commands cc20_datapath.
module cc20_controller import cc20_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  cc20_status_t status,
  output cc20_cmd_t    cmd
);

  // Four sub-steps per half-round, two half-rounds per double round
  localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
  localparam int STEP_COUNT    = DOUBLE_ROUNDS * 8;
  localparam int CNT_W         = $clog2(STEP_COUNT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FEED  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] step_cnt;
  logic [CNT_W-1:0] step_cnt_next;
  logic             accept;
  logic             last_step;

  assign in_stall  = !((state == ST_IDLE) && status.out_free);
  assign accept    = in_valid && !in_stall;
  assign last_step = (step_cnt == CNT_W'(STEP_COUNT - 1));

  // Next state and step counter
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept && status.pos_zero) begin
          state_next    = ST_ROUND;
          step_cnt_next = '0;
        end
      end
      ST_ROUND: begin
        step_cnt_next = step_cnt + CNT_W'(1);
        if (last_step) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd.accept   = accept;
    cmd.round_en = (state == ST_ROUND);
    cmd.qr_step  = step_cnt[1:0];
    cmd.diag     = step_cnt[2];
    cmd.feed     = (state == ST_FEED);
    cmd.emit     = (state == ST_EMIT) && status.out_free;
  end

endmodule

// ===== hw/rtl/chacha20_stream_cipher_unit.sv =====
// Top level of the ChaCha20 byte-stream cipher unit.
// Depends on cc20_pkg, cc20_controller and cc20_datapath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall   data_byte, last_byte
//   output   out        out_valid / out_stall out_byte, out_last
//   config   in         cfg_write            cfg_index, cfg_data
//
// A word inside a keystream block goes straight to the output register; the first word of
// a block waits for the round loop, which applies one quarter-round sub-step (one add,
// one xor-rotate) on four lanes a cycle, then for the feed-forward add and the emit.
// Synchronous reset clears position, block index, configuration and the output
// register; there is no clearing pass. A stalled output holds its word and stalls
// the input; a word is taken when the output register is free and no block is running.
module chacha20_stream_cipher_unit import cc20_pkg::*; #(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cc20_cmd_t    cmd;
  cc20_status_t status;

  cc20_controller #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cc20_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== hw/rtl/cc20_checker.sv =====
// Port-level checks for the ChaCha20 unit, bound to the top level.
// Depends only on the top level's handshake and output ports.
module cc20_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Output register is empty after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");

  // A blocked output back-pressures the input
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  // An accepted word is either delivered next or the unit is busy generating
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid || in_stall)
    else $error("accepted word neither delivered nor in progress");

endmodule

bind chacha20_stream_cipher_unit cc20_checker u_cc20_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
